// ----- rtl/boxf_pkg.sv -----
// ----------------------------------------------------------------------------
// boxf_pkg
// shared constants and codes for the 3x3 box filter stream
// ----------------------------------------------------------------------------
package boxf_pkg;

  localparam int unsigned DEFAULT_MAX_WIDTH = 1024;

  // configuration register widths and reset values
  localparam int unsigned IMAGE_WIDTH_W  = 11;
  localparam int unsigned IMAGE_HEIGHT_W = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_INDEX_W    = 1;

  localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 16'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // pixel and window arithmetic
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned SUM_W    = 12;  // nine 8-bit values
  localparam int unsigned DIV9_W   = 13;
  localparam logic [DIV9_W-1:0] DIV9_MUL = 13'd7282;  // ceil(2^16 / 9)
  localparam int unsigned DIV9_SHIFT = 16;
  localparam int unsigned PROD_W   = SUM_W + DIV9_W;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

endpackage

// ----- rtl/box_filter_3x3_stream.sv -----
// ----------------------------------------------------------------------------
// box_filter_3x3_stream
// streaming 3x3 mean filter with two line-store rams and a window register
// ----------------------------------------------------------------------------
// an input transfer passes the stage 1 and stage 2 registers into the output register
// throughput: one item per cycle; the pipeline holds only while a result waits
//   in the output register and out_stall_i is high
// line-store read is issued in stage 0 and written back in stage 1, same-column hits are forwarded
// reset: counters, window and pipeline valids clear, registers take their
//   defaults; line-store contents stay undefined until written
// ----------------------------------------------------------------------------
module box_filter_3x3_stream #(
  parameter int unsigned MAX_WIDTH = boxf_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input item channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic [boxf_pkg::PIX_W-1:0]       pixel_in_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [boxf_pkg::PIX_W-1:0]       pixel_out_o,
  output logic                             last_pixel_o,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [boxf_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [boxf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import boxf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);      // column address
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);  // column count
  localparam int unsigned HW = IMAGE_HEIGHT_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [IMAGE_WIDTH_W-1:0] image_width_q;
  logic [HW-1:0]            image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero reads as one, width clamps to the line-store depth
  logic [31:0]   width_ext;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  assign width_ext = 32'(image_width_q);

  always_comb begin
    if (width_ext == 32'd0) begin
      w_eff = CW'(1);
    end else if (width_ext > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_ext);
    end
  end

  assign h_eff = (image_height_q == '0) ? HW'(1) : image_height_q;

  // --------------------------------------------------------------------------
  // pipeline advance: everything moves unless a result is held back
  // --------------------------------------------------------------------------
  logic adv;
  logic in_acc;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  // --------------------------------------------------------------------------
  // stage 0: position counters, issue line-store read
  // --------------------------------------------------------------------------
  logic [AW-1:0] in_col_q,  in_col_d;
  logic [HW-1:0] in_row_q,  in_row_d;
  logic [AW-1:0] out_col_q, out_col_d;
  logic [HW-1:0] out_row_q, out_row_d;

  logic             emit;
  logic             in_col_end;
  logic             out_col_end;
  logic             out_row_end;
  logic             border;
  logic             last;
  logic [PIX_W-1:0] pix_v;

  assign pix_v = (opcode_i == OP_FLUSH) ? '0 : pixel_in_i;

  assign emit = (in_row_q >= HW'(2)) || (in_row_q == HW'(1) && in_col_q != '0);

  assign in_col_end  = (CW'(in_col_q) + CW'(1)) >= w_eff;
  assign out_col_end = (CW'(out_col_q) + CW'(1)) >= w_eff;
  assign out_row_end = ({1'b0, out_row_q} + (HW+1)'(1)) >= {1'b0, h_eff};

  assign border = (out_row_q == '0) || out_row_end || (out_col_q == '0) || out_col_end;
  assign last   = out_row_end && out_col_end;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (in_acc) begin
      if (in_col_end) begin
        in_col_d = '0;
        if (in_row_q != '1) begin
          in_row_d = in_row_q + HW'(1);
        end
      end else begin
        in_col_d = in_col_q + AW'(1);
      end
      if (emit) begin
        if (last) begin
          // image done, next item starts a new frame
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + HW'(1);
        end else begin
          out_col_d = out_col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: line-store data back, write-back and window shift
  // --------------------------------------------------------------------------
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic             s1_border_q;
  logic             s1_last_q;
  logic [AW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;

  // forwarding for a read that hit the column written in the same cycle
  logic             fwd_q;
  logic [PIX_W-1:0] fwd_top_q;
  logic [PIX_W-1:0] fwd_mid_q;

  logic             ram_we;
  logic [PIX_W-1:0] upper_rdata;
  logic [PIX_W-1:0] lower_rdata;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;

  assign ram_we = adv && s1_valid_q;
  assign top    = fwd_q ? fwd_top_q : upper_rdata;
  assign mid    = fwd_q ? fwd_mid_q : lower_rdata;

  boxf_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (mid),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (upper_rdata)
  );

  boxf_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_lower (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_acc),
    .raddr_i (in_col_q),
    .rdata_o (lower_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc;
      fwd_q      <= in_acc && s1_valid_q && (s1_addr_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_emit_q   <= emit;
      s1_border_q <= border;
      s1_last_q   <= last;
      s1_addr_q   <= in_col_q;
      s1_pix_q    <= pix_v;
      fwd_top_q   <= mid;
      fwd_mid_q   <= s1_pix_q;
    end
  end

  // 3x3 window, row-major, new column enters on the right
  logic [PIX_W-1:0] win_q [9];
  logic [SUM_W-1:0] win_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (ram_we) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= top;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= mid;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= s1_pix_q;
    end
  end

  // sum of the window as it stands after this shift
  assign win_sum = SUM_W'(win_q[1]) + SUM_W'(win_q[2]) + SUM_W'(top)
                 + SUM_W'(win_q[4]) + SUM_W'(win_q[5]) + SUM_W'(mid)
                 + SUM_W'(win_q[7]) + SUM_W'(win_q[8]) + SUM_W'(s1_pix_q);

  // --------------------------------------------------------------------------
  // stage 2: divide by nine via reciprocal, border bypass
  // --------------------------------------------------------------------------
  logic             s2_valid_q;
  logic             s2_border_q;
  logic             s2_last_q;
  logic [SUM_W-1:0] s2_sum_q;
  logic [PIX_W-1:0] s2_center_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_border_q <= s1_border_q;
      s2_last_q   <= s1_last_q;
      s2_sum_q    <= win_sum;
      s2_center_q <= win_q[5];  // center after the shift
    end
  end

  logic [PROD_W-1:0]            prod;
  logic [PROD_W-DIV9_SHIFT-1:0] quot;
  logic [PIX_W-1:0]             mean;
  logic [PIX_W-1:0]             result;

  assign prod   = PROD_W'(s2_sum_q) * PROD_W'(DIV9_MUL);
  assign quot   = prod[PROD_W-1:DIV9_SHIFT];
  assign mean   = (quot > (PROD_W-DIV9_SHIFT)'(PIX_MAX)) ? PIX_MAX : quot[PIX_W-1:0];
  assign result = s2_border_q ? s2_center_q : mean;

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixel_out_o  <= result;
      last_pixel_o <= s2_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_last_q |-> s2_border_q)
    else $error("last result not classed as border");

  a_fwd_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forwarding active with empty write-back stage");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(in_col_q) < CW'(MAX_WIDTH)) && (CW'(out_col_q) < CW'(MAX_WIDTH)))
    else $error("column counter beyond line-store depth");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(s2_valid_q) && $stable(s1_valid_q))
    else $error("pipeline moved while held");

endmodule

// ----- rtl/boxf_ram.sv -----
// ----------------------------------------------------------------------------
// boxf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module boxf_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read returns old contents on a same-address write
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- tb/box_filter_3x3_stream_tb.sv -----
// ----------------------------------------------------------------------------
// box_filter_3x3_stream_tb
// self-checking bench for the streaming 3x3 mean filter: a cycle-free
// predictor tracks line stores, window and raster counters per accepted
// transfer and every result transfer is checked against the oldest prediction
// ----------------------------------------------------------------------------
module box_filter_3x3_stream_tb;
  import boxf_pkg::*;

  localparam int unsigned MAX_W         = DEFAULT_MAX_WIDTH;
  localparam int unsigned RANDOM_ITEMS  = 1550;
  localparam int unsigned SETTLE_CYCLES = 8;        // margin for the pipeline to drain
  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int unsigned REPORT_MAX    = 10;

  // how pixel values are drawn for a frame
  typedef enum int unsigned {
    PIXELS_ANY,
    PIXELS_EXTREME,
    PIXELS_BRIGHT,
    PIXELS_DARK
  } pixel_mix_e;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filtered_pix_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   opcode = OP_PIXEL;
  logic [PIX_W-1:0]       pixel_in = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PIX_W-1:0]       pixel_out;
  logic                   last_pixel;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state, mirrors the block after reset
  logic [PIX_W-1:0]          upper_line [MAX_W];
  logic [PIX_W-1:0]          lower_line [MAX_W];
  logic [PIX_W-1:0]          win [9];
  int unsigned               in_col = 0;
  int unsigned               in_row = 0;
  int unsigned               out_col = 0;
  int unsigned               out_row = 0;
  logic [IMAGE_WIDTH_W-1:0]  width_reg = IMAGE_WIDTH_RST;
  logic [IMAGE_HEIGHT_W-1:0] height_reg = IMAGE_HEIGHT_RST;

  filtered_pix_t expected_pixels [$];
  int unsigned   transfers_in = 0;
  int unsigned   mismatches = 0;
  int unsigned   stall_left = 0;
  int unsigned   cycle_count = 0;
  bit            idle_on = 1'b1;

  box_filter_3x3_stream dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .pixel_in_i   (pixel_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_o  (pixel_out),
    .last_pixel_o (last_pixel),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int unsigned i = 0; i < MAX_W; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int unsigned i = 0; i < 9; i++) win[i] = '0;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("box_filter_3x3_stream test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor: one accepted item, zero or one filtered pixel queued
  // ---------------------------------------------------------------------------
  task automatic predict_filtered_pixel(input logic op, input logic [PIX_W-1:0] pix);
    int unsigned      w, h, c, sum, r;
    logic [PIX_W-1:0] v, top, mid;
    logic             emit, border, is_last;
    filtered_pix_t    result;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    // a flush is a zero pixel that keeps the raster moving
    v = (op == OP_FLUSH) ? '0 : pix;
    c = (in_col >= MAX_W) ? 0 : in_col;
    top = upper_line[c];
    mid = lower_line[c];
    upper_line[c] = mid;
    lower_line[c] = v;
    // window slides left, the new column enters on the right
    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;
    // a result needs the pixel one row and one column further on
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < 16'hFFFF) in_row++;  // input row count saturates
    end else begin
      in_col++;
    end
    if (emit) begin
      border  = (out_row == 0) || (out_row + 1 >= h) || (out_col == 0) || (out_col + 1 >= w);
      is_last = (out_row + 1 >= h) && (out_col + 1 >= w);
      if (border) begin
        result.pix = win[4];
      end else begin
        sum = 0;
        for (r = 0; r < 9; r++) sum += win[r];
        sum = sum / 9;
        result.pix = (sum > PIX_MAX) ? PIX_MAX : sum[PIX_W-1:0];
      end
      result.last = is_last;
      expected_pixels.push_back(result);
      // marked last pixel restarts the raster for the next frame
      if (is_last) begin
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
               mismatches, cycle_count, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall after each transfer while idle_on is set, checks against predictions
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    filtered_pix_t want;
    int unsigned   hold;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result transfer, pixel_out", 0, pixel_out);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out !== want.pix) report_mismatch("pixel_out", want.pix, pixel_out);
        if (last_pixel !== want.last) report_mismatch("last_pixel", want.last, last_pixel);
      end
      hold = idle_on ? $urandom_range(0, 3) : 0;
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // ---------------------------------------------------------------------------
  // input side helpers
  // ---------------------------------------------------------------------------
  // one input transfer, with a random gap in front of it while idle_on is set; returns on the
  // accepting edge with valid still high
  task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    pixel_in <= pix;
    do @(posedge clk_i); while (in_stall);
    predict_filtered_pixel(op, pix);
    transfers_in++;
  endtask

  // register writes only once the block has gone quiet
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = data[IMAGE_WIDTH_W-1:0];
    else height_reg = data[IMAGE_HEIGHT_W-1:0];
  endtask

  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] wdata,
                                input logic [CFG_DATA_W-1:0] hdata);
    write_reg(REG_IMAGE_WIDTH, wdata);
    write_reg(REG_IMAGE_HEIGHT, hdata);
  endtask

  function automatic logic [PIX_W-1:0] draw_pixel(input pixel_mix_e mix);
    case (mix)
      PIXELS_EXTREME: draw_pixel = $urandom_range(0, 1) ? PIX_MAX : '0;
      PIXELS_BRIGHT:  draw_pixel = $urandom_range(240, 255);
      PIXELS_DARK:    draw_pixel = $urandom_range(0, 15);
      default:        draw_pixel = $urandom_range(0, 255);
    endcase
  endfunction

  // flush until the predictor has seen the marked last pixel
  task automatic drain_frame();
    while (in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0)
      send_item(OP_FLUSH, draw_pixel(PIXELS_ANY));
  endtask

  // full frame at effective size, then a width+1 tail where extra_pct percent
  // of the tail items are stray pixels instead of flushes
  task automatic run_frame(input int unsigned cols, input int unsigned rows,
                           input pixel_mix_e mix, input int unsigned extra_pct);
    int unsigned n;
    for (n = 0; n < cols * rows; n++) send_item(OP_PIXEL, draw_pixel(mix));
    for (n = 0; n <= cols; n++) begin
      if ($urandom_range(0, 99) < extra_pct) send_item(OP_PIXEL, draw_pixel(mix));
      else send_item(OP_FLUSH, draw_pixel(PIXELS_ANY));
    end
    drain_frame();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // 3x3 checkerboard of full-scale values gives one interior pixel, then a
  // zero-sized frame that must behave as 1x1 with a stray pixel in its tail
  task automatic test_directed_small();
    int unsigned n;
    set_frame_size(3, 3);
    for (n = 0; n < 9; n++) send_item(OP_PIXEL, n[0] ? '0 : PIX_MAX);
    for (n = 0; n < 4; n++) send_item(OP_FLUSH, draw_pixel(PIXELS_ANY));
    set_frame_size(0, 0);
    send_item(OP_PIXEL, 8'hA5);
    send_item(OP_PIXEL, 8'h5A);
    send_item(OP_FLUSH, PIX_MAX);
    drain_frame();
  endtask

  // width and height shrink while a frame is half way through
  task automatic test_mid_frame_resize();
    int unsigned n;
    set_frame_size(6, 5);
    for (n = 0; n < 10; n++) send_item(OP_PIXEL, draw_pixel(PIXELS_ANY));
    write_reg(REG_IMAGE_WIDTH, 4);
    for (n = 0; n < 12; n++) send_item(OP_PIXEL, draw_pixel(PIXELS_ANY));
    write_reg(REG_IMAGE_HEIGHT, 2);
    drain_frame();
    // grow again mid frame, only over columns the line stores already hold
    set_frame_size(3, 3);
    for (n = 0; n < 5; n++) send_item(OP_PIXEL, draw_pixel(PIXELS_BRIGHT));
    set_frame_size(6, 4);
    drain_frame();
  endtask

  // mostly well-formed frames of random size and content, some with stray
  // items in front that shift the raster
  task automatic test_random_frames();
    int unsigned first, cols, rows;
    logic [CFG_DATA_W-1:0] wdata, hdata;
    first = transfers_in;
    while (transfers_in - first < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      cols = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 48);
      rows = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      // width register ignores the upper data bits
      wdata = ($urandom & 16'hF800) | cols[CFG_DATA_W-1:0];
      hdata = rows[CFG_DATA_W-1:0];
      if ($urandom_range(0, 19) == 0) begin
        wdata = ($urandom & 16'hF800);
        cols  = 1;
      end
      if ($urandom_range(0, 19) == 0) begin
        hdata = '0;
        rows  = 1;
      end
      set_frame_size(wdata, hdata);
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3))
          send_item($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL, draw_pixel(PIXELS_ANY));
      run_frame(cols, rows, pixel_mix_e'($urandom_range(0, 3)),
                ($urandom_range(0, 3) == 0) ? 40 : 0);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_small();
    test_mid_frame_resize();
    test_random_frames();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("box_filter_3x3_stream test passed");
    end else begin
      $display("box_filter_3x3_stream test failed");
    end
    $finish;
  end

endmodule

// ----- box_filter_3x3_stream.f -----
rtl/boxf_pkg.sv
rtl/boxf_ram.sv
rtl/box_filter_3x3_stream.sv
tb/box_filter_3x3_stream_tb.sv
